// ===== rtl/aajc_pkg.sv =====
`default_nettype none

package aajc_pkg;

   // Phase of the reverse-brake round and of the jog pulse train
   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_ACTIVE = 2'd1,
      PHASE_REST   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_MOVING  = 2'd0,
      STATUS_ARRIVED = 2'd1,
      STATUS_FAULT   = 2'd2
   } move_status_type;

   // Register index, byte address = 4 * index
   typedef enum logic [2:0] {
      REG_COARSE_BAND       = 3'd0,
      REG_FINE_BAND         = 3'd1,
      REG_GLITCH_LIMIT      = 3'd2,
      REG_JOG_ON_TICKS      = 3'd3,
      REG_JOG_OFF_TICKS     = 3'd4,
      REG_BRAKE_DRIVE_TICKS = 3'd5,
      REG_BRAKE_PAUSE_TICKS = 3'd6,
      REG_BRAKE_ROUNDS      = 3'd7
   } reg_index_type;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [14:0] COARSE_BAND_RESET       = 15'd2000;
   localparam logic [14:0] FINE_BAND_RESET         = 15'd200;
   localparam logic [3:0]  GLITCH_LIMIT_RESET      = 4'd10;
   localparam logic [7:0]  JOG_ON_TICKS_RESET      = 8'd10;
   localparam logic [7:0]  JOG_OFF_TICKS_RESET     = 8'd10;
   localparam logic [7:0]  BRAKE_DRIVE_TICKS_RESET = 8'd10;
   localparam logic [7:0]  BRAKE_PAUSE_TICKS_RESET = 8'd2;
   localparam logic [1:0]  BRAKE_ROUNDS_RESET      = 2'd2;

   typedef struct packed {
      logic [14:0] coarse_band;
      logic [14:0] fine_band;
      logic [3:0]  glitch_limit;
      logic [7:0]  jog_on_ticks;
      logic [7:0]  jog_off_ticks;
      logic [7:0]  brake_drive_ticks;
      logic [7:0]  brake_pause_ticks;
      logic [1:0]  brake_rounds;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] measured_distance;
      logic [14:0]        target_position;
      logic               timer_tick;
   } sample_type;

   typedef struct packed {
      logic            north_drive;
      logic            south_drive;
      move_status_type move_status;
   } result_type;

   // Per-beat events raised by the control step
   typedef struct packed {
      logic fault;
      logic arrive;
   } step_event_type;

endpackage

`default_nettype wire

// ===== rtl/aajc_req_if.sv =====
`default_nettype none

interface aajc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] measured_distance;
   logic [14:0]        target_position;
   logic               timer_tick;

   modport source (
      output valid, measured_distance, target_position, timer_tick,
      input  ready
   );

   modport sink (
      input  valid, measured_distance, target_position, timer_tick,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/aajc_rsp_if.sv =====
`default_nettype none

interface aajc_rsp_if;
   logic       valid;
   logic       ready;
   logic       north_drive;
   logic       south_drive;
   logic [1:0] move_status;

   modport source (
      output valid, north_drive, south_drive, move_status,
      input  ready
   );

   modport sink (
      input  valid, north_drive, south_drive, move_status,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/aajc_csr.sv =====
`default_nettype none

module aajc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [aajc_pkg::CsrAddrWidth-1:0]  paddr,
   input  wire logic [aajc_pkg::CsrDataWidth-1:0]  pwdata,
   output logic      [aajc_pkg::CsrDataWidth-1:0]  prdata,
   output logic                                    pready,
   output aajc_pkg::cfg_type                       cfg
);
   import aajc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_en;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite;
   assign reg_index = reg_index_type'(paddr[CsrAddrWidth-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_COARSE_BAND:       cfg_in.coarse_band       = pwdata[14:0];
            REG_FINE_BAND:         cfg_in.fine_band         = pwdata[14:0];
            REG_GLITCH_LIMIT:      cfg_in.glitch_limit      = pwdata[3:0];
            REG_JOG_ON_TICKS:      cfg_in.jog_on_ticks      = pwdata[7:0];
            REG_JOG_OFF_TICKS:     cfg_in.jog_off_ticks     = pwdata[7:0];
            REG_BRAKE_DRIVE_TICKS: cfg_in.brake_drive_ticks = pwdata[7:0];
            REG_BRAKE_PAUSE_TICKS: cfg_in.brake_pause_ticks = pwdata[7:0];
            REG_BRAKE_ROUNDS:      cfg_in.brake_rounds      = pwdata[1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coarse_band       <= COARSE_BAND_RESET;
         cfg_ff.fine_band         <= FINE_BAND_RESET;
         cfg_ff.glitch_limit      <= GLITCH_LIMIT_RESET;
         cfg_ff.jog_on_ticks      <= JOG_ON_TICKS_RESET;
         cfg_ff.jog_off_ticks     <= JOG_OFF_TICKS_RESET;
         cfg_ff.brake_drive_ticks <= BRAKE_DRIVE_TICKS_RESET;
         cfg_ff.brake_pause_ticks <= BRAKE_PAUSE_TICKS_RESET;
         cfg_ff.brake_rounds      <= BRAKE_ROUNDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_COARSE_BAND:       prdata = {17'd0, cfg_ff.coarse_band};
         REG_FINE_BAND:         prdata = {17'd0, cfg_ff.fine_band};
         REG_GLITCH_LIMIT:      prdata = {28'd0, cfg_ff.glitch_limit};
         REG_JOG_ON_TICKS:      prdata = {24'd0, cfg_ff.jog_on_ticks};
         REG_JOG_OFF_TICKS:     prdata = {24'd0, cfg_ff.jog_off_ticks};
         REG_BRAKE_DRIVE_TICKS: prdata = {24'd0, cfg_ff.brake_drive_ticks};
         REG_BRAKE_PAUSE_TICKS: prdata = {24'd0, cfg_ff.brake_pause_ticks};
         REG_BRAKE_ROUNDS:      prdata = {30'd0, cfg_ff.brake_rounds};
         default:               prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/aajc_ctrl.sv =====
`default_nettype none

module aajc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire aajc_pkg::cfg_type       cfg,
   input  wire aajc_pkg::sample_type    sample,
   input  wire logic                    advance,
   output aajc_pkg::result_type         result,
   output aajc_pkg::step_event_type     step_event
);
   import aajc_pkg::*;

   logic [3:0]      glitch_ff, glitch_in;
   logic [14:0]     last_good_ff, last_good_in;
   phase_type       brake_phase_ff, brake_phase_in;
   logic [7:0]      brake_timer_ff, brake_timer_in;
   logic [1:0]      rounds_done_ff, rounds_done_in;
   phase_type       jog_phase_ff, jog_phase_in;
   logic [7:0]      jog_timer_ff, jog_timer_in;
   logic            north_ff, north_in;
   logic            south_ff, south_in;
   move_status_type status_ff, status_in;

   logic        dist_neg;
   logic [14:0] dist_used;
   logic [16:0] err;
   logic [16:0] err_abs;
   logic [15:0] mag;
   logic        toward_north;
   logic        fault;
   logic        arrive;

   always_comb begin
      glitch_in      = glitch_ff;
      last_good_in   = last_good_ff;
      brake_phase_in = brake_phase_ff;
      brake_timer_in = brake_timer_ff;
      rounds_done_in = rounds_done_ff;
      jog_phase_in   = jog_phase_ff;
      jog_timer_in   = jog_timer_ff;
      north_in       = north_ff;
      south_in       = south_ff;
      status_in      = status_ff;
      fault          = 1'b0;
      arrive         = 1'b0;

      // advance timers before the control decision, saturate at full scale
      if (sample.timer_tick) begin
         if (brake_timer_ff != 8'hFF) brake_timer_in = brake_timer_ff + 8'd1;
         if (jog_timer_ff != 8'hFF)   jog_timer_in   = jog_timer_ff + 8'd1;
      end

      dist_neg  = sample.measured_distance[15];
      dist_used = sample.measured_distance[14:0];
      if (dist_neg) begin
         if (glitch_ff < cfg.glitch_limit) begin
            glitch_in = glitch_ff + 4'd1;
            dist_used = last_good_ff;
         end else begin
            north_in  = 1'b0;
            south_in  = 1'b0;
            glitch_in = 4'd0;
            status_in = STATUS_FAULT;
            fault     = 1'b1;
         end
      end else begin
         glitch_in    = 4'd0;
         last_good_in = sample.measured_distance[14:0];
      end

      err          = {2'b00, dist_used} - {2'b00, sample.target_position};
      err_abs      = err[16] ? (17'd0 - err) : err;
      mag          = err_abs[15:0];
      toward_north = !err[16];

      if (!fault) begin
         if (mag > {1'b0, cfg.coarse_band}) begin
            // far out: drive toward the target, leave the other relay alone
            if (toward_north) north_in = 1'b1;
            else              south_in = 1'b1;
         end else if (mag < {1'b0, cfg.coarse_band}) begin
            if (mag > {1'b0, cfg.fine_band}) begin
               if (rounds_done_ff < cfg.brake_rounds) begin
                  unique case (brake_phase_ff)
                     PHASE_ACTIVE: begin
                        if (brake_timer_in <= cfg.brake_drive_ticks) begin
                           if (toward_north) south_in = 1'b1;
                           else              north_in = 1'b1;
                        end else begin
                           brake_phase_in = PHASE_REST;
                           brake_timer_in = 8'd0;
                        end
                     end
                     PHASE_REST: begin
                        if (brake_timer_in <= cfg.brake_pause_ticks) begin
                           if (toward_north) south_in = 1'b0;
                           else              north_in = 1'b0;
                        end else begin
                           brake_phase_in = PHASE_ACTIVE;
                           brake_timer_in = 8'd0;
                           if (rounds_done_ff != 2'd3) rounds_done_in = rounds_done_ff + 2'd1;
                        end
                     end
                     default: begin
                        if (toward_north) north_in = 1'b0;
                        else              south_in = 1'b0;
                        brake_phase_in = PHASE_ACTIVE;
                     end
                  endcase
               end else begin
                  unique case (jog_phase_ff)
                     PHASE_ACTIVE: begin
                        if (jog_timer_in < cfg.jog_on_ticks) begin
                           if (toward_north) north_in = 1'b1;
                           else              south_in = 1'b1;
                        end else begin
                           jog_phase_in = PHASE_REST;
                           jog_timer_in = 8'd0;
                        end
                     end
                     PHASE_REST: begin
                        if (jog_timer_in < cfg.jog_off_ticks) begin
                           if (toward_north) north_in = 1'b0;
                           else              south_in = 1'b0;
                        end else begin
                           jog_phase_in = PHASE_ACTIVE;
                           jog_timer_in = 8'd0;
                        end
                     end
                     default: begin
                        brake_phase_in = PHASE_IDLE;
                        brake_timer_in = 8'd0;
                        jog_phase_in   = PHASE_ACTIVE;
                     end
                  endcase
               end
            end else begin
               // inside the fine band: stop and report arrival
               if (toward_north) north_in = 1'b0;
               else              south_in = 1'b0;
               rounds_done_in = 2'd0;
               jog_phase_in   = PHASE_IDLE;
               jog_timer_in   = 8'd0;
               status_in      = STATUS_ARRIVED;
               arrive         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glitch_ff      <= 4'd0;
         last_good_ff   <= 15'd0;
         brake_phase_ff <= PHASE_IDLE;
         brake_timer_ff <= 8'd0;
         rounds_done_ff <= 2'd0;
         jog_phase_ff   <= PHASE_IDLE;
         jog_timer_ff   <= 8'd0;
         north_ff       <= 1'b0;
         south_ff       <= 1'b0;
         status_ff      <= STATUS_MOVING;
      end else if (advance) begin
         glitch_ff      <= glitch_in;
         last_good_ff   <= last_good_in;
         brake_phase_ff <= brake_phase_in;
         brake_timer_ff <= brake_timer_in;
         rounds_done_ff <= rounds_done_in;
         jog_phase_ff   <= jog_phase_in;
         jog_timer_ff   <= jog_timer_in;
         north_ff       <= north_in;
         south_ff       <= south_in;
         status_ff      <= status_in;
      end
   end

   assign result.north_drive = north_in;
   assign result.south_drive = south_in;
   assign result.move_status = status_in;
   assign step_event.fault   = fault;
   assign step_event.arrive  = arrive;

endmodule

`default_nettype wire

// ===== rtl/axis_approach_jog_controller.sv =====
`default_nettype none

// Approach and jog controller for one crane axis (north/south relays).
// Each request beat carries a laser distance, a target position and a timer
// tick; each one yields exactly one response beat with both relay commands
// and the move status (moving, arrived, sensor fault; the status is sticky).
// Negative distances count as glitches and are bridged with the last good
// reading up to glitch_limit in a row, after which both relays drop and a
// fault is reported. Far from the target the axis drives continuously;
// inside the coarse band it runs brake_rounds reverse-brake rounds, then
// pulse-jogs until the error falls within the fine band. Timing registers
// count ticks, not clocks. Throughput is one beat per clock while the
// response side is not stalling: the request is held in an input register,
// and one pass of compare logic updates the axis state and loads the
// response register once that register is free or being drained. A
// stalled response holds in its register while one more request still lands
// in the input register. The register
// port is APB style (byte address 4*index, pready tied high); write it only
// while no beat is in flight.
module axis_approach_jog_controller (
   input  wire logic                               clock,
   input  wire logic                               reset,
   aajc_req_if.sink                                req_chan,
   aajc_rsp_if.source                              rsp_chan,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [aajc_pkg::CsrAddrWidth-1:0]  paddr,
   input  wire logic [aajc_pkg::CsrDataWidth-1:0]  pwdata,
   output logic      [aajc_pkg::CsrDataWidth-1:0]  prdata,
   output logic                                    pready
);
   import aajc_pkg::*;

   cfg_type        cfg;
   sample_type     sample_ff, sample_in;
   logic           in_valid_ff, in_valid_in;
   result_type     result_ff, result_in;
   logic           out_valid_ff, out_valid_in;
   step_event_type step_event;
   logic           req_fire;
   logic           advance;

   aajc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Move the held beat through the control step when the response
   // register is free or being drained this cycle.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      sample_in = sample_ff;
      if (req_fire) begin
         sample_in.measured_distance = req_chan.measured_distance;
         sample_in.target_position   = req_chan.target_position;
         sample_in.timer_tick        = req_chan.timer_tick;
      end
   end

   always_comb begin
      priority if (req_fire) in_valid_in = 1'b1;
      else if (advance)      in_valid_in = 1'b0;
      else                   in_valid_in = in_valid_ff;
   end

   aajc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .sample     (sample_ff),
      .advance    (advance),
      .result     (result_in),
      .step_event (step_event)
   );

   always_comb begin
      priority if (advance)    out_valid_in = 1'b1;
      else if (rsp_chan.ready) out_valid_in = 1'b0;
      else                     out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on a new beat, hold otherwise
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.north_drive = result_ff.north_drive;
   assign rsp_chan.south_drive = result_ff.south_drive;
   assign rsp_chan.move_status = result_ff.move_status;

   // A sensor fault must leave both relays off in the response it produces.
   assert property (@(posedge clock) disable iff (reset)
      advance && step_event.fault |=>
         !result_ff.north_drive && !result_ff.south_drive &&
         (result_ff.move_status == STATUS_FAULT))
      else $error("fault beat did not drop both relays");

   // Arrival loads the arrived status into the response register.
   assert property (@(posedge clock) disable iff (reset)
      advance && step_event.arrive |=> (result_ff.move_status == STATUS_ARRIVED))
      else $error("arrival beat did not report arrived");

   // The request side only stalls when both stages are full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff && out_valid_ff && !rsp_chan.ready)
      else $error("request stalled with room in the pipeline");

   // A response appears only from a beat held in the input register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("response raised without a held request");

endmodule

`default_nettype wire
